@@ design/lvm_pkg.sv @@
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared word sizes, row codes and transaction types of the look-at view
// matrix unit.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int LvmWordBits = 32;
  localparam int LvmFracBits = 16;
  localparam int LvmRowBits  = 2;

  localparam logic [LvmRowBits-1:0] RowFirst = 2'd0;
  localparam logic [LvmRowBits-1:0] RowLast  = 2'd3;

  typedef struct packed {
    logic signed [LvmWordBits-1:0] eye_x;
    logic signed [LvmWordBits-1:0] eye_y;
    logic signed [LvmWordBits-1:0] eye_z;
    logic signed [LvmWordBits-1:0] target_x;
    logic signed [LvmWordBits-1:0] target_y;
    logic signed [LvmWordBits-1:0] target_z;
    logic signed [LvmWordBits-1:0] up_x;
    logic signed [LvmWordBits-1:0] up_y;
    logic signed [LvmWordBits-1:0] up_z;
  } lvm_in_t;

  typedef struct packed {
    logic [LvmRowBits-1:0]         row;
    logic signed [LvmWordBits-1:0] col_0;
    logic signed [LvmWordBits-1:0] col_1;
    logic signed [LvmWordBits-1:0] col_2;
    logic signed [LvmWordBits-1:0] col_3;
    logic                          last;
    logic                          degenerate;
  } lvm_out_t;

endpackage

@@ design/lvm_norm.sv @@
// ----------------------------------------------------------------------------
// lvm_norm
// Pipelined 3-vector normalizer: magnitude, common scaling shift, sum of
// squares, one square-root digit per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lvm_norm #(
  parameter int IN_W   = 33,
  parameter int FRAC_W = 16,
  parameter int SB_W   = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [2:0][IN_W-1:0]     vec_i,
  input  logic [SB_W-1:0]          sb_i,
  output logic                     valid_o,
  output logic [2:0][FRAC_W+1:0]   unit_o,
  output logic                     zero_o,
  output logic [SB_W-1:0]          sb_o
);

  localparam int NW   = 30;              // normalized magnitude width
  localparam int EW   = IN_W + NW;
  localparam int PW   = $clog2(EW);
  localparam int RW   = 63;              // root remainder width
  localparam int SQ_N = 32;              // root digits
  localparam int LW   = 31;              // length width
  localparam int Q    = FRAC_W + 1;      // quotient bits
  localparam int DW   = LW + Q;
  localparam int UW   = FRAC_W + 2;

  typedef struct packed {
    logic                 zero;
    logic [2:0]           neg;
    logic [2:0][NW-1:0]   n;
    logic [SB_W-1:0]      sb;
  } side_t;

  // magnitudes
  logic [2:0][IN_W-1:0] mag_d;
  logic [2:0][IN_W-1:0] mag_a_q;
  logic [2:0]           neg_a_q;
  logic [SB_W-1:0]      sb_a_q;
  logic                 vld_a_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = vec_i[k][IN_W-1] ? (~vec_i[k] + 1'b1) : vec_i[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_d;
      sb_a_q  <= sb_i;
      for (int k = 0; k < 3; k++) begin
        neg_a_q[k] <= vec_i[k][IN_W-1];
      end
    end
  end

  // locate the leading one of the largest magnitude
  logic [IN_W-1:0]      orv;
  logic [PW-1:0]        pos_d;
  logic [PW-1:0]        pos_b_q;
  logic                 zero_b_q;
  logic [2:0][IN_W-1:0] mag_b_q;
  logic [2:0]           neg_b_q;
  logic [SB_W-1:0]      sb_b_q;
  logic                 vld_b_q;

  always_comb begin
    orv   = mag_a_q[0] | mag_a_q[1] | mag_a_q[2];
    pos_d = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (orv[i]) pos_d = PW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_b_q  <= pos_d;
      zero_b_q <= (orv == '0);
      mag_b_q  <= mag_a_q;
      neg_b_q  <= neg_a_q;
      sb_b_q   <= sb_a_q;
    end
  end

  // scale so the largest magnitude has its top bit at NW-1
  logic [2:0][NW-1:0] n_d;
  side_t              c_side_q;
  logic               vld_c_q;

  always_comb begin
    logic [EW-1:0] ext;
    logic [EW-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      ext = EW'(mag_b_q[k]);
      if (pos_b_q >= PW'(NW - 1)) begin
        sh = ext >> (pos_b_q - PW'(NW - 1));
      end else begin
        sh = ext << (PW'(NW - 1) - pos_b_q);
      end
      n_d[k] = sh[NW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_side_q.zero <= zero_b_q;
      c_side_q.neg  <= neg_b_q;
      c_side_q.n    <= n_d;
      c_side_q.sb   <= sb_b_q;
    end
  end

  // squares
  logic [2:0][2*NW-1:0] sq_q;
  side_t                d_side_q;
  logic                 vld_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= c_side_q.n[k] * c_side_q.n[k];
      end
      d_side_q <= c_side_q;
    end
  end

  // square root, one result digit per stage
  logic [RW-1:0] sq_rem_q  [SQ_N+1];
  logic [RW-1:0] sq_res_q  [SQ_N+1];
  side_t         sq_side_q [SQ_N+1];
  logic          sq_vld_q  [SQ_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_vld_q[0] <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_rem_q[0]  <= RW'(sq_q[0]) + RW'(sq_q[1]) + RW'(sq_q[2]);
      sq_res_q[0]  <= '0;
      sq_side_q[0] <= d_side_q;
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (SQ_N - 1 - j));
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = sq_res_q[j] + Bit;
      ge    = (sq_rem_q[j] >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[j+1] <= sq_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[j+1]  <= ge ? (sq_rem_q[j] - trial) : sq_rem_q[j];
        sq_res_q[j+1]  <= ge ? ((sq_res_q[j] >> 1) + Bit) : (sq_res_q[j] >> 1);
        sq_side_q[j+1] <= sq_side_q[j];
      end
    end
  end

  // division of each scaled magnitude by the length, one quotient bit per stage
  logic [LW-1:0]        len;
  logic [2:0][DW-1:0]   dv_rem_q  [Q+1];
  logic [2:0][Q-1:0]    dv_quo_q  [Q+1];
  logic [LW-1:0]        dv_len_q  [Q+1];
  side_t                dv_side_q [Q+1];
  logic                 dv_vld_q  [Q+1];

  assign len = sq_res_q[SQ_N][LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= sq_vld_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem_q[0][k] <= DW'({sq_side_q[SQ_N].n[k], FRAC_W'(0)}) + DW'(len >> 1);
      end
      dv_quo_q[0]  <= '0;
      dv_len_q[0]  <= len;
      dv_side_q[0] <= sq_side_q[SQ_N];
    end
  end

  for (genvar s = 0; s < Q; s++) begin : g_div
    localparam int B = Q - 1 - s;
    logic [DW-1:0] dsh;

    assign dsh = DW'(dv_len_q[s]) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[s+1] <= dv_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem_q[s][k] >= dsh) begin
            dv_rem_q[s+1][k]    <= dv_rem_q[s][k] - dsh;
            dv_quo_q[s+1][k]    <= dv_quo_q[s][k] | (Q'(1) << B);
          end else begin
            dv_rem_q[s+1][k]    <= dv_rem_q[s][k];
            dv_quo_q[s+1][k]    <= dv_quo_q[s][k];
          end
        end
        dv_len_q[s+1]  <= dv_len_q[s];
        dv_side_q[s+1] <= dv_side_q[s];
      end
    end
  end

  // apply signs, force the result of a zero vector to zero
  logic [2:0][UW-1:0] unit_q;
  logic               zero_q;
  logic [SB_W-1:0]    sb_q;
  logic               vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= dv_vld_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_side_q[Q].zero) begin
          unit_q[k] <= '0;
        end else if (dv_side_q[Q].neg[k]) begin
          unit_q[k] <= UW'(0) - UW'(dv_quo_q[Q][k]);
        end else begin
          unit_q[k] <= UW'(dv_quo_q[Q][k]);
        end
      end
      zero_q <= dv_side_q[Q].zero;
      sb_q   <= dv_side_q[Q].sb;
    end
  end

  assign valid_o = vld_q;
  assign unit_o  = unit_q;
  assign zero_o  = zero_q;
  assign sb_o    = sb_q;

endmodule

@@ design/lookat_view_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// lookat_view_matrix_unit
// Left-handed look-at view matrix: forward, right and true-up axes from
// eye, target and up, emitted as four row transactions.
// ----------------------------------------------------------------------------
// Path: from accept to row 0 an item passes two normalizers in series, each of
//   FRACTION_BITS+40 stages, set by the 32 root stages.
// Output: rows 0..3 leave the four-row output register in order; while it
//   is full it holds the whole pipeline until row 3 is taken.
// Reset: asynchronous, clears all valid bits and the row counter.
// ----------------------------------------------------------------------------
module lookat_view_matrix_unit #(
  parameter int FRACTION_BITS = lvm_pkg::LvmFracBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lvm_pkg::lvm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lvm_pkg::lvm_out_t out_data_o
);

  import lvm_pkg::*;

  localparam int W    = LvmWordBits;
  localparam int F    = FRACTION_BITS;
  localparam int UW   = F + 2;
  localparam int PRW  = 2 * UW;
  localparam int XW   = PRW + 1;
  localparam int YW   = UW + 1;
  localparam int EPW  = UW + W;
  localparam int EYW  = YW + W;
  localparam int DTW  = UW + W + 2;
  localparam int SATW = DTW + 1;
  localparam int SBX  = 3 * W + 3 * UW + 1;

  localparam logic signed [SATW-1:0] SatHi = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SATW-1:0] SatLo = ~SatHi;
  localparam logic signed [DTW-1:0]  DtHalf = DTW'(1) << (F - 1);
  localparam logic signed [XW-1:0]   YHalf  = XW'(1) << (F - 1);
  localparam logic [W-1:0]           OneVal = (F < W - 1) ? (W'(1) << F) : SatHi[W-1:0];

  function automatic logic [W-1:0] sat_w(input logic signed [SATW-1:0] v);
    if (v > SatHi) begin
      return SatHi[W-1:0];
    end else if (v < SatLo) begin
      return SatLo[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] neg_round_sat(input logic signed [DTW-1:0] s);
    logic signed [DTW-1:0] r;
    r = (s + DtHalf) >>> F;
    return sat_w(-(SATW'(r)));
  endfunction

  logic adv;

  // capture the transaction and form target minus eye
  logic [2:0][W-1:0] eye_in;
  logic [2:0][W-1:0] tgt_in;
  logic [2:0][W-1:0] up_in;
  logic [2:0][W:0]   d_in;

  always_comb begin
    eye_in = {in_data_i.eye_z, in_data_i.eye_y, in_data_i.eye_x};
    tgt_in = {in_data_i.target_z, in_data_i.target_y, in_data_i.target_x};
    up_in  = {in_data_i.up_z, in_data_i.up_y, in_data_i.up_x};
    for (int k = 0; k < 3; k++) begin
      d_in[k] = {tgt_in[k][W-1], tgt_in[k]} - {eye_in[k][W-1], eye_in[k]};
    end
  end

  logic              vld1_q;
  logic [2:0][W-1:0] eye1_q;
  logic [2:0][W:0]   d1_q;
  logic [2:0][W-1:0] up1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      eye1_q <= eye_in;
      d1_q   <= d_in;
      up1_q  <= up_in;
    end
  end

  // normalize up and forward side by side
  logic [2:0][UW-1:0] upn_w;
  logic [2:0][UW-1:0] z_w;
  logic               up_zero;
  logic               d_zero;
  logic               up_vld;
  logic               d_vld;
  logic [0:0]         up_sb;
  logic [3*W-1:0]     eye_d_sb;

  lvm_norm #(.IN_W(W), .FRAC_W(F), .SB_W(1)) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld1_q),
    .vec_i   (up1_q),
    .sb_i    (vld1_q),
    .valid_o (up_vld),
    .unit_o  (upn_w),
    .zero_o  (up_zero),
    .sb_o    (up_sb)
  );

  lvm_norm #(.IN_W(W + 1), .FRAC_W(F), .SB_W(3 * W)) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld1_q),
    .vec_i   (d1_q),
    .sb_i    (eye1_q),
    .valid_o (d_vld),
    .unit_o  (z_w),
    .zero_o  (d_zero),
    .sb_o    (eye_d_sb)
  );

  // right axis products
  logic signed [PRW-1:0] pa [3];
  logic signed [PRW-1:0] pb [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = $signed(upn_w[(k+1)%3]) * $signed(z_w[(k+2)%3]);
      pb[k] = $signed(upn_w[(k+2)%3]) * $signed(z_w[(k+1)%3]);
    end
  end

  logic                 vld_x1_q;
  logic [2:0][PRW-1:0]  pa_q;
  logic [2:0][PRW-1:0]  pb_q;
  logic [2:0][UW-1:0]   z_x1_q;
  logic [3*W-1:0]       eye_x1_q;
  logic                 deg_x1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_x1_q <= 1'b0;
    end else if (adv) begin
      vld_x1_q <= up_vld & up_sb[0] & d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[k] <= pa[k];
        pb_q[k] <= pb[k];
      end
      z_x1_q   <= z_w;
      eye_x1_q <= eye_d_sb;
      deg_x1_q <= up_zero | d_zero;
    end
  end

  // right axis differences
  logic                vld_x2_q;
  logic [2:0][XW-1:0]  xr_q;
  logic [2:0][UW-1:0]  z_x2_q;
  logic [3*W-1:0]      eye_x2_q;
  logic                deg_x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_x2_q <= 1'b0;
    end else if (adv) begin
      vld_x2_q <= vld_x1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        xr_q[k] <= XW'($signed(pa_q[k])) - XW'($signed(pb_q[k]));
      end
      z_x2_q   <= z_x1_q;
      eye_x2_q <= eye_x1_q;
      deg_x2_q <= deg_x1_q;
    end
  end

  // normalize the right axis
  logic [2:0][UW-1:0] x_w;
  logic               x_zero;
  logic               x_vld;
  logic [SBX-1:0]     x_sb;
  logic               deg_n;
  logic [2:0][UW-1:0] z_n;
  logic [2:0][W-1:0]  eye_n;

  lvm_norm #(.IN_W(XW), .FRAC_W(F), .SB_W(SBX)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_x2_q),
    .vec_i   (xr_q),
    .sb_i    ({deg_x2_q, z_x2_q, eye_x2_q}),
    .valid_o (x_vld),
    .unit_o  (x_w),
    .zero_o  (x_zero),
    .sb_o    (x_sb)
  );

  assign {deg_n, z_n, eye_n} = x_sb;

  // true up products and eye products of right and forward
  logic signed [PRW-1:0] ya [3];
  logic signed [PRW-1:0] yb [3];
  logic signed [EPW-1:0] ex [3];
  logic signed [EPW-1:0] ez [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ya[k] = $signed(z_n[(k+1)%3]) * $signed(x_w[(k+2)%3]);
      yb[k] = $signed(z_n[(k+2)%3]) * $signed(x_w[(k+1)%3]);
      ex[k] = $signed(x_w[k]) * $signed(eye_n[k]);
      ez[k] = $signed(z_n[k]) * $signed(eye_n[k]);
    end
  end

  logic                vld_y1_q;
  logic [2:0][PRW-1:0] ya_q;
  logic [2:0][PRW-1:0] yb_q;
  logic [2:0][EPW-1:0] ex_q;
  logic [2:0][EPW-1:0] ez_q;
  logic [2:0][UW-1:0]  x_y1_q;
  logic [2:0][UW-1:0]  z_y1_q;
  logic [2:0][W-1:0]   eye_y1_q;
  logic                deg_y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_y1_q <= 1'b0;
    end else if (adv) begin
      vld_y1_q <= x_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ya_q[k] <= ya[k];
        yb_q[k] <= yb[k];
        ex_q[k] <= ex[k];
        ez_q[k] <= ez[k];
      end
      x_y1_q   <= x_w;
      z_y1_q   <= z_n;
      eye_y1_q <= eye_n;
      deg_y1_q <= deg_n | x_zero;
    end
  end

  // round the true up axis, finish right and forward translations
  logic [2:0][YW-1:0] y_d;

  always_comb begin
    logic signed [XW-1:0] diff;
    for (int k = 0; k < 3; k++) begin
      diff   = XW'($signed(ya_q[k])) - XW'($signed(yb_q[k])) + YHalf;
      y_d[k] = YW'(diff >>> F);
    end
  end

  logic               vld_y2_q;
  logic [2:0][YW-1:0] y_y2_q;
  logic [2:0][UW-1:0] x_y2_q;
  logic [2:0][UW-1:0] z_y2_q;
  logic [2:0][W-1:0]  eye_y2_q;
  logic [W-1:0]       tx_y2_q;
  logic [W-1:0]       tz_y2_q;
  logic               deg_y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_y2_q <= 1'b0;
    end else if (adv) begin
      vld_y2_q <= vld_y1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_y2_q   <= y_d;
      x_y2_q   <= x_y1_q;
      z_y2_q   <= z_y1_q;
      eye_y2_q <= eye_y1_q;
      tx_y2_q  <= neg_round_sat(DTW'($signed(ex_q[0])) + DTW'($signed(ex_q[1]))
                                + DTW'($signed(ex_q[2])));
      tz_y2_q  <= neg_round_sat(DTW'($signed(ez_q[0])) + DTW'($signed(ez_q[1]))
                                + DTW'($signed(ez_q[2])));
      deg_y2_q <= deg_y1_q;
    end
  end

  // true up eye products, saturate the axes
  logic signed [EYW-1:0] ey [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ey[k] = $signed(y_y2_q[k]) * $signed(eye_y2_q[k]);
    end
  end

  logic                vld_y3_q;
  logic [2:0][EYW-1:0] ey_q;
  logic [2:0][W-1:0]   xs_q;
  logic [2:0][W-1:0]   ys_q;
  logic [2:0][W-1:0]   zs_q;
  logic [W-1:0]        tx_y3_q;
  logic [W-1:0]        tz_y3_q;
  logic                deg_y3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_y3_q <= 1'b0;
    end else if (adv) begin
      vld_y3_q <= vld_y2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ey_q[k] <= ey[k];
        xs_q[k] <= sat_w(SATW'($signed(x_y2_q[k])));
        ys_q[k] <= sat_w(SATW'($signed(y_y2_q[k])));
        zs_q[k] <= sat_w(SATW'($signed(z_y2_q[k])));
      end
      tx_y3_q  <= tx_y2_q;
      tz_y3_q  <= tz_y2_q;
      deg_y3_q <= deg_y2_q;
    end
  end

  // output register: four rows, then free for the next transaction
  logic [W-1:0]                  ty;
  logic                          ser_full_q;
  logic [LvmRowBits-1:0]         row_q;
  logic [2:0][W-1:0]             ser_col_q [4];
  logic                          ser_deg_q;

  assign ty  = neg_round_sat(DTW'($signed(ey_q[0])) + DTW'($signed(ey_q[1]))
                             + DTW'($signed(ey_q[2])));
  assign adv = !ser_full_q || (!out_stall_i && (row_q == RowLast));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_full_q <= 1'b0;
      row_q      <= RowFirst;
    end else if (adv) begin
      ser_full_q <= vld_y3_q;
      row_q      <= RowFirst;
    end else if (!out_stall_i) begin
      row_q <= row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        ser_col_q[r] <= {zs_q[r], ys_q[r], xs_q[r]};
      end
      ser_col_q[3] <= {tz_y3_q, ty, tx_y3_q};
      ser_deg_q    <= deg_y3_q;
    end
  end

  // drive the result transaction
  always_comb begin
    out_data_o.row        = row_q;
    out_data_o.col_0      = ser_col_q[row_q][0];
    out_data_o.col_1      = ser_col_q[row_q][1];
    out_data_o.col_2      = ser_col_q[row_q][2];
    out_data_o.col_3      = (row_q == RowLast) ? OneVal : '0;
    out_data_o.last       = (row_q == RowLast);
    out_data_o.degenerate = ser_deg_q;
  end

  assign out_valid_o = ser_full_q;
  assign in_stall_o  = !adv;

endmodule

@@ tb/tb_lookat_view_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// tb_lookat_view_matrix_unit
// Self-checking bench for the look-at view matrix unit. Directed cameras
// (degenerate vectors, extreme words, saturating translations) are followed
// by random cameras. A built-in fixed-point model predicts all four rows of
// every accepted transaction. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the pipeline fills up.
// ----------------------------------------------------------------------------
module tb_lookat_view_matrix_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lvm_pkg::*;

  localparam int  Frac     = LvmFracBits;
  localparam int  CycLimit = 200000;
  localparam int  HoldLen  = 600;
  localparam int  NumRand  = 210;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  lvm_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lvm_out_t out_data_o;

  lvm_in_t  cam_pending_q[$];
  lvm_out_t view_rows_q[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       cyc = 0;
  logic     rx_hold = 1'b0;

  lookat_view_matrix_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---- fixed-point view matrix predictor ----
  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_frac(longint v);
    return (v + (64'sd1 <<< (Frac - 1))) >>> Frac;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Return 1 when the vector has zero length (unit vector forced to zero).
  function automatic bit unit_vec(input longint a, b, c, output longint ua, ub, uc);
    longint unsigned ma, mb, mc, mx, len;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mc = (c < 0) ? -c : c;
    mx = ma;
    if (mb > mx) mx = mb;
    if (mc > mx) mx = mc;
    ua = 0; ub = 0; uc = 0;
    if (mx == 0) return 1'b1;
    // Bring the largest magnitude into [2^29, 2^30).
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1; ma = ma >> 1; mb = mb >> 1; mc = mc >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1; ma = ma << 1; mb = mb << 1; mc = mc << 1;
    end
    len = int_sqrt(ma * ma + mb * mb + mc * mc);
    ua = longint'(((ma << Frac) + (len >> 1)) / len);
    ub = longint'(((mb << Frac) + (len >> 1)) / len);
    uc = longint'(((mc << Frac) + (len >> 1)) / len);
    if (a < 0) ua = -ua;
    if (b < 0) ub = -ub;
    if (c < 0) uc = -uc;
    return 1'b0;
  endfunction

  function automatic longint neg_dot_eye(longint a0, a1, a2, e0, e1, e2);
    longint k, r;
    k = a0 * (e0 >>> Frac) + a1 * (e1 >>> Frac) + a2 * (e2 >>> Frac);
    r = a0 * (e0 & 64'hffff) + a1 * (e1 & 64'hffff) + a2 * (e2 & 64'hffff);
    return sat_word(-(k + round_frac(r)));
  endfunction

  task automatic push_view_rows(lvm_in_t c);
    longint ex, ey, ez, ux, uy, uz, zx, zy, zz, rx, ry, rz, xx, xy, xz, yx, yy, yz;
    longint tx, ty, tz;
    bit degen;
    lvm_out_t r;
    ex = c.eye_x; ey = c.eye_y; ez = c.eye_z;
    degen = unit_vec(c.up_x, c.up_y, c.up_z, ux, uy, uz);
    degen |= unit_vec(longint'(c.target_x) - ex, longint'(c.target_y) - ey,
                      longint'(c.target_z) - ez, zx, zy, zz);
    rx = uy * zz - uz * zy;
    ry = uz * zx - ux * zz;
    rz = ux * zy - uy * zx;
    degen |= unit_vec(rx, ry, rz, xx, xy, xz);
    yx = round_frac(zy * xz - zz * xy);
    yy = round_frac(zz * xx - zx * xz);
    yz = round_frac(zx * xy - zy * xx);
    tx = neg_dot_eye(xx, xy, xz, ex, ey, ez);
    ty = neg_dot_eye(yx, yy, yz, ex, ey, ez);
    tz = neg_dot_eye(zx, zy, zz, ex, ey, ez);
    r.degenerate = degen;
    r.last = 1'b0;
    r.col_3 = '0;
    r.row = RowFirst;
    r.col_0 = 32'(sat_word(xx)); r.col_1 = 32'(sat_word(yx)); r.col_2 = 32'(sat_word(zx));
    view_rows_q.push_back(r);
    r.row = RowFirst + 2'd1;
    r.col_0 = 32'(sat_word(xy)); r.col_1 = 32'(sat_word(yy)); r.col_2 = 32'(sat_word(zy));
    view_rows_q.push_back(r);
    r.row = RowFirst + 2'd2;
    r.col_0 = 32'(sat_word(xz)); r.col_1 = 32'(sat_word(yz)); r.col_2 = 32'(sat_word(zz));
    view_rows_q.push_back(r);
    r.row = RowLast;
    r.last = 1'b1;
    r.col_0 = 32'(tx); r.col_1 = 32'(ty); r.col_2 = 32'(tz);
    r.col_3 = 32'(sat_word(64'sd1 <<< Frac));
    view_rows_q.push_back(r);
  endtask

  // Quiet stretches: no idling on either side for one window in three.
  function automatic int draw_gap();
    if ((cyc / 90) % 3 == 0) return 0;
    return $urandom_range(0, 6);
  endfunction

  // ---- camera driver ----
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        push_view_rows(in_data_i);
        n_sent <= n_sent + 1;
        void'(cam_pending_q.pop_front());
        tx_gap = draw_gap();
        if (tx_gap == 0 && cam_pending_q.size() > 0) begin
          in_data_i <= cam_pending_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (cam_pending_q.size() > 0) begin
          in_data_i  <= cam_pending_q[0];
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // ---- long receiver hold-off, once the pipeline has traffic ----
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (!hold_done && n_sent >= 40) begin
      hold_cnt++;
      if (hold_cnt >= HoldLen) begin
        rx_hold <= 1'b0;
        hold_done = 1'b1;
      end else begin
        rx_hold <= 1'b1;
      end
    end
  end

  // ---- row monitor ----
  int rx_wait = 0;
  always @(posedge clk_i) begin
    lvm_out_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (view_rows_q.size() == 0) begin
          $display("%0t: unexpected row transaction %p", $realtime, out_data_o);
          n_errors++;
        end else begin
          e = view_rows_q.pop_front();
          if (out_data_o.row !== e.row) begin
            $display("%0t: row exp %0d got %0d", $realtime, e.row, out_data_o.row);
            n_errors++;
          end
          if (out_data_o.col_0 !== e.col_0) begin
            $display("%0t: col_0 exp %0d got %0d", $realtime, e.col_0, out_data_o.col_0);
            n_errors++;
          end
          if (out_data_o.col_1 !== e.col_1) begin
            $display("%0t: col_1 exp %0d got %0d", $realtime, e.col_1, out_data_o.col_1);
            n_errors++;
          end
          if (out_data_o.col_2 !== e.col_2) begin
            $display("%0t: col_2 exp %0d got %0d", $realtime, e.col_2, out_data_o.col_2);
            n_errors++;
          end
          if (out_data_o.col_3 !== e.col_3) begin
            $display("%0t: col_3 exp %0d got %0d", $realtime, e.col_3, out_data_o.col_3);
            n_errors++;
          end
          if (out_data_o.last !== e.last) begin
            $display("%0t: last exp %0b got %0b", $realtime, e.last, out_data_o.last);
            n_errors++;
          end
          if (out_data_o.degenerate !== e.degenerate) begin
            $display("%0t: degenerate exp %0b got %0b", $realtime, e.degenerate,
                     out_data_o.degenerate);
            n_errors++;
          end
        end
        rx_wait = draw_gap();
      end
      out_stall_i <= rx_hold || (rx_wait > 0);
      if (rx_wait > 0) rx_wait--;
    end
  end

  // ---- cycle limit ----
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---- stimulus ----
  function automatic logic [31:0] pick_word(int kind);
    case (kind)
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 6)) - 3) <<< 16;
    endcase
  endfunction

  function automatic lvm_in_t make_cam(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    lvm_in_t c;
    c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
    c.target_x = tx; c.target_y = ty; c.target_z = tz;
    c.up_x = ux; c.up_y = uy; c.up_z = uz;
    return c;
  endfunction

  initial begin
    logic [31:0] one, mx, mn;
    lvm_in_t c;
    int kind;
    one = 32'h0001_0000;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    // Directed cameras: ordinary view, zero vectors, parallel up, extremes.
    cam_pending_q.push_back(make_cam(0, 0, -5 * one, 0, 0, 0, 0, one, 0));
    cam_pending_q.push_back(make_cam(0, 0, 0, 0, 0, 0, 0, 0, 0));
    cam_pending_q.push_back(make_cam(one, one, one, one, one, one, 0, one, 0));
    cam_pending_q.push_back(make_cam(0, 0, 0, 0, 0, one, 0, 0, 0));
    cam_pending_q.push_back(make_cam(0, 0, 0, 0, one, 0, 0, 3 * one, 0));
    cam_pending_q.push_back(make_cam(0, 0, 0, 0, -one, 0, 0, one, 0));
    cam_pending_q.push_back(make_cam(mn, mn, mn, mx, mx, mx, 0, one, 0));
    cam_pending_q.push_back(make_cam(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    cam_pending_q.push_back(make_cam(mx, 0, 0, mx, 0, mx, 0, mx, 0));
    cam_pending_q.push_back(make_cam(mn, mx, mn, mn, mn, mx, mn, 0, 1));
    cam_pending_q.push_back(make_cam(mx, mx, mx, mx, mx, mn, 1, 0, 0));
    cam_pending_q.push_back(make_cam(mn, mn, mn, mn, mx, mn, 0, 0, mn));
    cam_pending_q.push_back(make_cam(1, -1, 1, 0, 0, 0, -1, 1, 1));
    cam_pending_q.push_back(make_cam(32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff));
    cam_pending_q.push_back(make_cam(3 * one, 2 * one, -one, -one, 0, one, one, one, 0));
    cam_pending_q.push_back(make_cam(32'hffff_8000, 32'h0000_8000, 32'h7fff_8000,
                                     0, one, 0, 0, 0, -one));
    cam_pending_q.push_back(make_cam(0, 0, 0, 2, 0, 0, 5, 0, 0));
    cam_pending_q.push_back(make_cam(0, 0, 0, -7, -7, -7, 1, 1, 1));
    // Random cameras, mostly well-formed views with some raw words mixed in.
    for (int i = 0; i < NumRand; i++) begin
      kind = $urandom_range(0, 3);
      c = make_cam(pick_word(kind), pick_word(kind), pick_word(kind),
                   pick_word(kind), pick_word(kind), pick_word(kind),
                   pick_word($urandom_range(0, 3)), pick_word($urandom_range(0, 3)),
                   pick_word($urandom_range(0, 3)));
      if ($urandom_range(0, 15) == 0) c.up_x = c.target_x - c.eye_x;
      cam_pending_q.push_back(c);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cam_pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (view_rows_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lvm_pkg.sv
design/lvm_norm.sv
design/lookat_view_matrix_unit.sv
tb/tb_lookat_view_matrix_unit.sv
